@@ hdl/lru_cache_directory_assert.svh @@
// ----------------------------------------------------------------------------
// LRU cache directory assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_DIRECTORY_ASSERT_SVH
`define LRU_CACHE_DIRECTORY_ASSERT_SVH
`ifndef SYNTHESIS
`define LCD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lru_cache_directory: assertion failed");
`define LCD_ASSERT_NEVER(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("lru_cache_directory: forbidden condition seen");
`else
`define LCD_ASSERT(label, clk, rst, prop)
`define LCD_ASSERT_NEVER(label, clk, rst, prop)
`endif
`endif

@@ hdl/lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU cache directory package
// Payload types, cell command types and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd_pkg;

   localparam int KEY_BITS     = 32;
   localparam int WAYS_W       = 4;
   localparam int SLOT_W       = 3;
   localparam int EVKEY_W      = 32;
   localparam int CAPACITY_DEF = 8;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd8;

   // register index, taken from paddr above the byte offset
   localparam logic [0:0] REG_WAYS_IN_USE = 1'b0;

   localparam logic ACT_REFERENCE = 1'b0;
   localparam logic ACT_QUERY     = 1'b1;

   typedef struct packed {
      logic                action;
      logic [KEY_BITS-1:0] key;
      logic                refresh;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic               store_payload;
      logic               evicted;
      logic [EVKEY_W-1:0] evicted_key;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_IDLE,
      OP_LOOK,
      OP_PROMOTE,
      OP_INSERT
   } lcd_op_type;

   typedef struct packed {
      lcd_op_type op;
      logic       use_victim;
   } lcd_cmd_type;

   typedef struct packed {
      logic match;
      logic victim;
      logic first_free;
   } lcd_flag_type;

endpackage

`default_nettype wire

@@ hdl/lru_cache_directory.sv @@
// A transaction passes a lookup step in the cell chain, then an update step that
// also loads the result register; a new transaction can be accepted during the
// update step, but not during the lookup.
// A stalled result holds the update cycle until the result register frees up.
// Reset (synchronous, active high) clears all valid bits, ranks and occupancy
// and sets ways_in_use to 8; no clearing pass is needed.
// ----------------------------------------------------------------------------
// LRU cache directory
// Fully associative LRU directory built as a chain of entry cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_cache_directory_assert.svh"

module lru_cache_directory
   import lcd_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (OCC_W > WAYS_W) ? OCC_W : WAYS_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_UPDT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [WAYS_W-1:0] ways_ff;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   req_type           req_hold_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_fire, can_finish, upd_fire, csr_write;
   logic              full, hit, do_ref, do_insert, do_evict;
   logic [OCC_W-1:0]  occ_m1;
   lcd_cmd_type       cmd;

   logic                free_seen [CAPACITY+1];
   logic [IDX_W-1:0]    rank_acc  [CAPACITY+1];
   logic [KEY_BITS-1:0] key_acc   [CAPACITY+1];
   lcd_flag_type        flags     [CAPACITY];
   logic [CAPACITY-1:0] match_vec, victim_vec, free_vec, target_vec;
   logic [IDX_W-1:0]    match_slot, victim_slot, free_slot, slot_sel;
   logic [IDX_W+SLOT_W-1:0] slot_wide;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite &&
                      (paddr[CSR_ADDR_W-1:2] == REG_WAYS_IN_USE);
   assign prdata    = (paddr[CSR_ADDR_W-1:2] == REG_WAYS_IN_USE) ?
                      CSR_DATA_W'(ways_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= WAYS_RESET;
      end else if (csr_write) begin
         ways_ff <= pwdata[WAYS_W-1:0];
      end
   end

   // handshake
   assign can_finish = ~rsp_valid_ff | rsp_ready;
   assign upd_fire   = (state_ff == ST_UPDT) && can_finish;
   assign req_ready  = (state_ff == ST_IDLE) || upd_fire;
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_LOOK;
         ST_LOOK: state_in = ST_UPDT;
         ST_UPDT: if (can_finish) state_in = req_fire ? ST_LOOK : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_hold_ff <= req_data;
      end
   end

   // cell chain
   assign occ_m1       = occ_ff - 1'b1;
   assign free_seen[0] = 1'b0;
   assign rank_acc[0]  = '0;
   assign key_acc[0]   = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      lcd_cell #(
         .CAPACITY (CAPACITY)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .key_in        (req_hold_ff.key),
         .last_rank     (occ_m1[IDX_W-1:0]),
         .promote_rank  (rank_acc[CAPACITY]),
         .free_seen_in  (free_seen[g]),
         .free_seen_out (free_seen[g+1]),
         .rank_acc_in   (rank_acc[g]),
         .rank_acc_out  (rank_acc[g+1]),
         .key_acc_in    (key_acc[g]),
         .key_acc_out   (key_acc[g+1]),
         .flags         (flags[g])
      );
      assign match_vec[g]  = flags[g].match;
      assign victim_vec[g] = flags[g].victim;
      assign free_vec[g]   = flags[g].first_free;
   end

   always_comb begin
      match_slot  = '0;
      victim_slot = '0;
      free_slot   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i])  match_slot  = match_slot  | IDX_W'(i);
         if (victim_vec[i]) victim_slot = victim_slot | IDX_W'(i);
         if (free_vec[i])   free_slot   = free_slot   | IDX_W'(i);
      end
   end

   // decision for the held transaction
   assign full = (CMP_W'(occ_ff) >= CMP_W'(CAPACITY)) ||
                 ((ways_ff == '0) ? (occ_ff != '0) :
                                    (CMP_W'(occ_ff) >= CMP_W'(ways_ff)));
   assign hit        = |match_vec;
   assign do_ref     = (req_hold_ff.action == ACT_REFERENCE);
   assign do_insert  = ~hit && do_ref;
   assign do_evict   = do_insert && full;
   assign target_vec = do_evict ? victim_vec : free_vec;

   always_comb begin
      cmd.op         = OP_IDLE;
      cmd.use_victim = do_evict;
      if (state_ff == ST_LOOK) begin
         cmd.op = OP_LOOK;
      end else if (upd_fire) begin
         if (hit && do_ref) begin
            cmd.op = OP_PROMOTE;
         end else if (do_insert) begin
            cmd.op = OP_INSERT;
         end
      end
   end

   always_comb begin
      priority if (hit) begin
         slot_sel = match_slot;
      end else if (do_evict) begin
         slot_sel = victim_slot;
      end else if (do_insert) begin
         slot_sel = free_slot;
      end else begin
         slot_sel = '0;
      end
   end

   assign slot_wide = {{SLOT_W{1'b0}}, slot_sel};

   always_comb begin
      rsp_data_in.hit           = hit;
      rsp_data_in.slot          = slot_wide[SLOT_W-1:0];
      rsp_data_in.store_payload = do_insert || (hit && do_ref && req_hold_ff.refresh);
      rsp_data_in.evicted       = do_evict;
      rsp_data_in.evicted_key   = do_evict ? EVKEY_W'(key_acc[CAPACITY]) : '0;
   end

   always_comb begin
      occ_in = occ_ff;
      if (upd_fire && do_insert && ~do_evict) begin
         occ_in = occ_ff + 1'b1;
      end
   end

   // result register; drop valid once taken unless a new result lands
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LCD_ASSERT(a_occ_bound, clock, reset, occ_ff <= OCC_W'(CAPACITY))
   `LCD_ASSERT(a_hit_unique, clock, reset, (state_ff == ST_UPDT) |-> $onehot0(match_vec))
   `LCD_ASSERT(a_ins_target, clock, reset, (upd_fire && do_insert) |-> $onehot(target_vec))
   `LCD_ASSERT_NEVER(a_evict_on_hit, clock, reset, rsp_valid_ff && rsp_data_ff.evicted && rsp_data_ff.hit)

endmodule

`default_nettype wire

@@ hdl/lcd_cell.sv @@
// ----------------------------------------------------------------------------
// LRU cache directory cell
// One directory entry: key, valid bit and recency rank, with lookup flags
// and the chain terms handed on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_cell
   import lcd_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lcd_cmd_type                  cmd,
   input  wire logic [KEY_BITS-1:0]          key_in,
   input  wire logic [$clog2(CAPACITY)-1:0]  last_rank,
   input  wire logic [$clog2(CAPACITY)-1:0]  promote_rank,
   input  wire logic                         free_seen_in,
   output logic                              free_seen_out,
   input  wire logic [$clog2(CAPACITY)-1:0]  rank_acc_in,
   output logic [$clog2(CAPACITY)-1:0]       rank_acc_out,
   input  wire logic [KEY_BITS-1:0]          key_acc_in,
   output logic [KEY_BITS-1:0]               key_acc_out,
   output lcd_flag_type                      flags
);

   localparam int RANK_W = $clog2(CAPACITY);

   logic [KEY_BITS-1:0] key_ff;
   logic                valid_ff, valid_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   lcd_flag_type        flags_ff, flags_in;
   logic                load_key;

   assign free_seen_out = free_seen_in | ~valid_ff;
   assign rank_acc_out  = rank_acc_in | (flags_ff.match ? rank_ff : '0);
   assign key_acc_out   = key_acc_in | (flags_ff.victim ? key_ff : '0);
   assign flags         = flags_ff;

   always_comb begin
      flags_in = flags_ff;
      valid_in = valid_ff;
      rank_in  = rank_ff;
      load_key = 1'b0;
      unique case (cmd.op)
         OP_IDLE: begin
         end
         OP_LOOK: begin
            flags_in.match      = valid_ff && (key_ff == key_in);
            flags_in.victim     = valid_ff && (rank_ff == last_rank);
            flags_in.first_free = ~valid_ff & ~free_seen_in;
         end
         OP_PROMOTE: begin
            if (flags_ff.match) begin
               rank_in = '0;
            end else if (valid_ff && (rank_ff < promote_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            // the victim's slot, or the first free slot if none is evicted, is reused; other valid entries age by one
            if (cmd.use_victim ? flags_ff.victim : flags_ff.first_free) begin
               load_key = 1'b1;
               valid_in = 1'b1;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_key) begin
         key_ff <= key_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/sv/lru_cache_directory_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU cache directory testbench
// Drives reference and query transactions through the directory under random
// back-pressure and several ways_in_use settings, and checks every response
// against a behavioral LRU model kept in a small scoreboard class.
// ----------------------------------------------------------------------------

module lru_cache_directory_tb;
   import lcd_pkg::*;

   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  LONG_HOLD    = 300;
   localparam int  SEGMENTS     = 4;
   localparam int  SEG_ITEMS    = 146;
   localparam int  POOL_MAX     = 12;

   // Behavioral LRU directory plus the queue of responses it predicts.
   class lru_shadow;
      logic [KEY_BITS-1:0] keys [CAPACITY_DEF];
      bit                  valid [CAPACITY_DEF];
      int                  rank [CAPACITY_DEF];
      int                  occupancy;
      logic [WAYS_W-1:0]   ways;
      rsp_type             expected_q [$];
      int                  errors;

      function new();
         for (int i = 0; i < CAPACITY_DEF; i++) begin
            keys[i] = '0;
            valid[i] = 1'b0;
            rank[i] = 0;
         end
         occupancy = 0;
         ways = WAYS_RESET;
         errors = 0;
      endfunction

      function void set_ways(logic [WAYS_W-1:0] value);
         ways = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(req_type item);
         rsp_type exp_rsp;
         int      found;
         int      victim;
         int      limit;
         int      old_rank;
         exp_rsp = '0;
         found = -1;
         victim = -1;
         for (int i = 0; i < CAPACITY_DEF; i++)
            if (found < 0 && valid[i] && keys[i] == item.key)
               found = i;
         if (found >= 0) begin
            exp_rsp.hit = 1'b1;
            exp_rsp.slot = SLOT_W'(found);
            if (item.action == ACT_REFERENCE) begin
               old_rank = rank[found];
               for (int i = 0; i < CAPACITY_DEF; i++)
                  if (valid[i] && rank[i] < old_rank)
                     rank[i]++;
               rank[found] = 0;
               exp_rsp.store_payload = item.refresh;
            end
         end else if (item.action == ACT_REFERENCE) begin
            // zero acts as one way, anything above capacity as full capacity
            limit = (ways == 0) ? 1 : (ways > CAPACITY_DEF) ? CAPACITY_DEF : int'(ways);
            if (occupancy >= limit)
               for (int i = 0; i < CAPACITY_DEF; i++)
                  if (valid[i] && (victim < 0 || rank[i] >= rank[victim]))
                     victim = i;
            if (victim >= 0) begin
               exp_rsp.evicted = 1'b1;
               exp_rsp.evicted_key = keys[victim];
               valid[victim] = 1'b0;
            end else begin
               for (int i = 0; i < CAPACITY_DEF; i++)
                  if (victim < 0 && !valid[i])
                     victim = i;
               occupancy++;
            end
            for (int i = 0; i < CAPACITY_DEF; i++)
               if (valid[i])
                  rank[i]++;
            keys[victim] = item.key;
            valid[victim] = 1'b1;
            rank[victim] = 0;
            exp_rsp.slot = SLOT_W'(victim);
            exp_rsp.store_payload = 1'b1;
         end
         expected_q.push_back(exp_rsp);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         errors++;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("response with no transaction outstanding: 0x%0h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.hit !== want.hit)
            report("hit", want.hit, got.hit);
         if (got.slot !== want.slot)
            report("slot", want.slot, got.slot);
         if (got.store_payload !== want.store_payload)
            report("store_payload", want.store_payload, got.store_payload);
         if (got.evicted !== want.evicted)
            report("evicted", want.evicted, got.evicted);
         if (got.evicted_key !== want.evicted_key)
            report("evicted_key", want.evicted_key, got.evicted_key);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   lru_shadow shadow = new();
   int        send_idle_pct = 0;
   int        rcv_idle_pct = 0;
   bit        hold_rsp_req = 1'b0;
   int        cycle_count = 0;

   logic [KEY_BITS-1:0] key_pool [POOL_MAX];
   int                  pool_size;

   lru_cache_directory DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lru_cache_directory_tb: errors");
         $finish;
      end
   end

   // Note accepted requests before checking responses at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            shadow.note_request(req_data);
         if (rsp_valid && rsp_ready)
            shadow.check_response(rsp_data);
      end
   end

   // Response side: random back-pressure, or one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp_req = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   function automatic req_type make_req(logic action, logic [KEY_BITS-1:0] key,
                                        logic refresh);
      req_type item;
      item.action = action;
      item.key = key;
      item.refresh = refresh;
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so the next call decides whether to drop it.
   task automatic send_request(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (shadow.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_ways(logic [WAYS_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({REG_WAYS_IN_USE, 2'b00});
      pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      shadow.set_ways(value);
   endtask

   function automatic req_type random_req();
      logic [KEY_BITS-1:0] key;
      if ($urandom_range(99) < 80)
         key = key_pool[$urandom_range(pool_size - 1)];
      else
         key = $urandom;
      return make_req(($urandom_range(99) < 25) ? ACT_QUERY : ACT_REFERENCE, key,
                      $urandom_range(1));
   endfunction

   logic [WAYS_W-1:0] ways_plan [3*SEGMENTS] = '{
      4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd8, 4'd4, 4'd6, 4'd7, 4'd9
   };

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty query, both key extremes, promote with and without
      // refresh, query hit, fill and evict at the default setting
      send_request(make_req(ACT_QUERY, '0, 1'b1));
      send_request(make_req(ACT_REFERENCE, '0, 1'b1));
      send_request(make_req(ACT_REFERENCE, '1, 1'b0));
      send_request(make_req(ACT_REFERENCE, '0, 1'b0));
      send_request(make_req(ACT_REFERENCE, '0, 1'b1));
      send_request(make_req(ACT_QUERY, '1, 1'b1));
      for (int i = 0; i < 6; i++)
         send_request(make_req(ACT_REFERENCE, 32'h1 << (5 * i), i[0]));
      send_request(make_req(ACT_REFERENCE, 32'hA5A5_A5A5, 1'b0));
      send_request(make_req(ACT_QUERY, 32'h0BAD_F00D, 1'b0));
      settle();

      // shrink the limit below the current occupancy
      write_ways(4'd2);
      send_request(make_req(ACT_REFERENCE, 32'h5A5A_5A5A, 1'b1));
      send_request(make_req(ACT_REFERENCE, 32'h0000_0020, 1'b0));
      send_request(make_req(ACT_REFERENCE, '0, 1'b1));
      settle();

      // zero behaves as one way, fifteen as full capacity
      write_ways(4'd0);
      send_request(make_req(ACT_REFERENCE, 32'h1234_5678, 1'b0));
      send_request(make_req(ACT_QUERY, 32'h1234_5678, 1'b0));
      send_request(make_req(ACT_REFERENCE, 32'hFFFF_0000, 1'b1));
      settle();
      write_ways(4'd15);
      send_request(make_req(ACT_REFERENCE, 32'h8765_4321, 1'b0));
      send_request(make_req(ACT_REFERENCE, 32'hFFFF_0000, 1'b0));
      send_request(make_req(ACT_QUERY, 32'h8765_4321, 1'b1));
      settle();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 28;
               rcv_idle_pct = 76;
            end
            1: begin
               send_idle_pct = 76;
               rcv_idle_pct = 28;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_ways(ways_plan[mode * SEGMENTS + seg]);
            pool_size = $urandom_range(POOL_MAX, 2);
            for (int i = 0; i < POOL_MAX; i++)
               key_pool[i] = $urandom;
            // stall the response side while requests keep coming
            if (mode == 0 && seg == 1)
               hold_rsp_req = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++)
               send_request(random_req());
            settle();
         end
      end

      if (shadow.errors == 0) begin
         $display("lru_cache_directory_tb: clean");
      end else begin
         $display("lru_cache_directory_tb: errors");
      end
      $finish;
   end

endmodule
